// ----- rtl/core/esc_pkg.sv -----
// shared types, symbol codes, error codes and character helpers for the syntax checker
package esc_pkg;

  localparam int SYM_W = 4;

  typedef enum logic [SYM_W-1:0] {
    SYM_E     = 4'd0,
    SYM_Q     = 4'd1,
    SYM_T     = 4'd2,
    SYM_R     = 4'd3,
    SYM_F     = 4'd4,
    SYM_N     = 4'd5,
    SYM_PLUS  = 4'd6,
    SYM_MINUS = 4'd7,
    SYM_MUL   = 4'd8,
    SYM_DIV   = 4'd9,
    SYM_LP    = 4'd10,
    SYM_RP    = 4'd11
  } sym_t;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_OPERAND  = 4'd1;
  localparam logic [3:0] ERR_BAD_Q    = 4'd2;
  localparam logic [3:0] ERR_BAD_R    = 4'd3;
  localparam logic [3:0] ERR_MISMATCH = 4'd4;
  localparam logic [3:0] ERR_DOUBLE   = 4'd5;
  localparam logic [3:0] ERR_OP_PAREN = 4'd6;
  localparam logic [3:0] ERR_TRAILING = 4'd7;
  localparam logic [3:0] ERR_OVERFLOW = 4'd8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic       done;
    logic       accepted;
    logic [3:0] code;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic [7:0] term_char(input sym_t s);
    logic [7:0] r;
    case (s)
      SYM_PLUS:  r = CH_PLUS;
      SYM_MINUS: r = CH_MINUS;
      SYM_MUL:   r = CH_MUL;
      SYM_DIV:   r = CH_DIV;
      SYM_LP:    r = CH_LP;
      SYM_RP:    r = CH_RP;
      default:   r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/esc_stack_ram.sv -----
// symbol stack memory, one write port and one registered read port
module esc_stack_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/esc_engine.sv -----
// parser sequencer: pops, expands and pushes the symbol stack one step per cycle
module esc_engine #(
  parameter int STACK_DEPTH = 64,
  parameter int AW          = 6,
  parameter int DW          = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_symbol,
  input  logic                     in_is_end,
  output logic                     res_valid,
  input  logic                     res_ready,
  output esc_pkg::res_t            res,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [esc_pkg::SYM_W-1:0] mem_wdata,
  output logic [AW-1:0]            mem_raddr,
  input  logic [esc_pkg::SYM_W-1:0] mem_rdata
);
  import esc_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_PUSH,
    S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [3:0]    err_r, err_nxt;
  logic          op_r, op_nxt;
  logic [1:0]    nph_r, nph_nxt;
  logic          topv_r, topv_nxt;
  sym_t          top_r, top_nxt;
  logic [7:0]    c_r, c_nxt;
  logic          end_r, end_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  sym_t          q0_r, q0_nxt;
  sym_t          q1_r, q1_nxt;

  logic [DW-1:0] dm1;
  logic [DW-1:0] dnxt_m1;
  sym_t          top_sym;
  sym_t          wsym;

  assign in_tready = (state_r == S_IDLE);
  assign dm1       = depth_r - DW'(1);
  assign top_sym   = topv_r ? top_r : sym_t'(mem_rdata);
  assign dnxt_m1   = depth_nxt - DW'(1);
  assign mem_raddr = dnxt_m1[AW-1:0];
  assign mem_wdata = wsym;

  assign res.done     = end_r;
  assign res.accepted = end_r && (err_r == ERR_NONE);
  assign res.code     = err_r;

  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    err_nxt   = err_r;
    op_nxt    = op_r;
    nph_nxt   = nph_r;
    topv_nxt  = topv_r;
    top_nxt   = top_r;
    c_nxt     = c_r;
    end_nxt   = end_r;
    cnt_nxt   = cnt_r;
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    mem_we    = 1'b0;
    mem_waddr = dm1[AW-1:0];
    wsym      = SYM_E;
    res_valid = 1'b0;

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        wsym      = SYM_E;
        depth_nxt = DW'(1);
        topv_nxt  = 1'b1;
        top_nxt   = SYM_E;
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_tvalid) begin
          c_nxt   = in_is_end ? CH_NUL : in_symbol;
          end_nxt = in_is_end;
          if (in_is_end) begin
            nph_nxt   = 2'd0;
            state_nxt = S_EXEC;
          end else if (err_r != ERR_NONE) begin
            state_nxt = S_DONE;
          end else if (nph_r == 2'd1) begin
            if (is_digit(in_symbol)) begin
              state_nxt = S_DONE;
            end else if (in_symbol == CH_DOT) begin
              nph_nxt   = 2'd2;
              state_nxt = S_DONE;
            end else begin
              nph_nxt   = 2'd0;
              state_nxt = S_EXEC;
            end
          end else if (nph_r == 2'd2) begin
            if (is_digit(in_symbol)) begin
              state_nxt = S_DONE;
            end else begin
              nph_nxt   = 2'd0;
              state_nxt = S_EXEC;
            end
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (err_r != ERR_NONE) begin
          state_nxt = S_DONE;
        end else if (depth_r == '0) begin
          if (!end_r) begin
            err_nxt = ERR_TRAILING;
          end
          state_nxt = S_DONE;
        end else begin
          // pop by default, a first push reuses the popped slot
          depth_nxt = dm1;
          topv_nxt  = 1'b0;
          case (top_sym)
            SYM_E, SYM_T: begin
              if (is_digit(c_r) || c_r == CH_LP || c_r == CH_MINUS) begin
                mem_we    = 1'b1;
                wsym      = (top_sym == SYM_E) ? SYM_Q : SYM_R;
                depth_nxt = depth_r;
                topv_nxt  = 1'b1;
                top_nxt   = wsym;
                q0_nxt    = (top_sym == SYM_E) ? SYM_T : SYM_F;
                cnt_nxt   = 2'd1;
                state_nxt = S_PUSH;
              end else begin
                err_nxt   = ERR_OPERAND;
                state_nxt = S_DONE;
              end
            end
            SYM_Q: begin
              if (c_r == CH_PLUS || c_r == CH_MINUS) begin
                if (op_r) begin
                  err_nxt   = ERR_DOUBLE;
                  state_nxt = S_DONE;
                end else begin
                  mem_we    = 1'b1;
                  wsym      = SYM_Q;
                  depth_nxt = depth_r;
                  topv_nxt  = 1'b1;
                  top_nxt   = SYM_Q;
                  q0_nxt    = SYM_T;
                  q1_nxt    = (c_r == CH_PLUS) ? SYM_PLUS : SYM_MINUS;
                  cnt_nxt   = 2'd2;
                  op_nxt    = 1'b1;
                  state_nxt = S_PUSH;
                end
              end else if (c_r == CH_RP || c_r == CH_NUL) begin
                op_nxt = 1'b0;
              end else begin
                err_nxt   = ERR_BAD_Q;
                state_nxt = S_DONE;
              end
            end
            SYM_R: begin
              if (c_r == CH_MUL || c_r == CH_DIV) begin
                if (op_r) begin
                  err_nxt   = ERR_DOUBLE;
                  state_nxt = S_DONE;
                end else begin
                  mem_we    = 1'b1;
                  wsym      = SYM_R;
                  depth_nxt = depth_r;
                  topv_nxt  = 1'b1;
                  top_nxt   = SYM_R;
                  q0_nxt    = SYM_F;
                  q1_nxt    = (c_r == CH_MUL) ? SYM_MUL : SYM_DIV;
                  cnt_nxt   = 2'd2;
                  op_nxt    = 1'b1;
                  state_nxt = S_PUSH;
                end
              end else if (c_r == CH_PLUS || c_r == CH_MINUS || c_r == CH_RP
                           || c_r == CH_NUL) begin
                op_nxt = 1'b0;
              end else begin
                err_nxt   = ERR_BAD_R;
                state_nxt = S_DONE;
              end
            end
            SYM_F: begin
              if (is_digit(c_r)) begin
                mem_we    = 1'b1;
                wsym      = SYM_N;
                depth_nxt = depth_r;
                topv_nxt  = 1'b1;
                top_nxt   = SYM_N;
                op_nxt    = 1'b0;
              end else if (c_r == CH_MINUS) begin
                // unary minus: the character is consumed here
                mem_we    = 1'b1;
                wsym      = SYM_F;
                depth_nxt = depth_r;
                topv_nxt  = 1'b1;
                top_nxt   = SYM_F;
                op_nxt    = 1'b0;
                state_nxt = S_DONE;
              end else if (c_r == CH_LP) begin
                if (op_r) begin
                  err_nxt   = ERR_OP_PAREN;
                  state_nxt = S_DONE;
                end else begin
                  mem_we    = 1'b1;
                  wsym      = SYM_RP;
                  depth_nxt = depth_r;
                  topv_nxt  = 1'b1;
                  top_nxt   = SYM_RP;
                  q0_nxt    = SYM_E;
                  q1_nxt    = SYM_LP;
                  cnt_nxt   = 2'd2;
                  op_nxt    = 1'b0;
                  state_nxt = S_PUSH;
                end
              end else begin
                err_nxt   = ERR_OPERAND;
                state_nxt = S_DONE;
              end
            end
            SYM_N: begin
              if (is_digit(c_r)) begin
                nph_nxt   = 2'd1;
                state_nxt = S_DONE;
              end else if (c_r == CH_DOT) begin
                nph_nxt   = 2'd2;
                state_nxt = S_DONE;
              end
            end
            default: begin
              if (c_r != CH_NUL && c_r == term_char(top_sym)) begin
                op_nxt = 1'b0;
              end else begin
                err_nxt = ERR_MISMATCH;
              end
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_PUSH: begin
        if (depth_r >= DW'(STACK_DEPTH)) begin
          err_nxt   = ERR_OVERFLOW;
          state_nxt = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = depth_r[AW-1:0];
          wsym      = q0_r;
          depth_nxt = depth_r + DW'(1);
          topv_nxt  = 1'b1;
          top_nxt   = q0_r;
          q0_nxt    = q1_r;
          cnt_nxt   = cnt_r - 2'd1;
          if (cnt_r == 2'd1) begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (end_r) begin
            err_nxt   = ERR_NONE;
            op_nxt    = 1'b0;
            nph_nxt   = 2'd0;
            state_nxt = S_INIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      depth_r <= '0;
      err_r   <= ERR_NONE;
      op_r    <= 1'b0;
      nph_r   <= 2'd0;
      topv_r  <= 1'b0;
      cnt_r   <= 2'd0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
      op_r    <= op_nxt;
      nph_r   <= nph_nxt;
      topv_r  <= topv_nxt;
      cnt_r   <= cnt_nxt;
      end_r   <= end_nxt;
    end
    top_r <= top_nxt;
    c_r   <= c_nxt;
    q0_r  <= q0_nxt;
    q1_r  <= q1_nxt;
  end

endmodule

// ----- rtl/core/expression_syntax_checker_unit.sv -----
// top level of the expression syntax checker: sequencer, stack memory and result register
// path: a character taken inside a number or after an error goes straight to the result register,
//   any other first passes through stack steps (pop, expansion or extra push); out_tvalid is registered
// flow: one item at a time, no new input is taken until its result has entered the result register
// after an end beat's result is taken, the start symbol is rewritten into the stack memory
// reset: synchronous active low; the first cycle after reset writes the start symbol, tready low
module expression_syntax_checker_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] accepted, [4:1] error_code, [7:5] zero
  output logic       out_tlast
);
  import esc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [SYM_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [SYM_W-1:0] mem_rdata;

  logic             out_valid_r;
  res_t             out_res_r;
  logic             res_fire;
  logic             in_fire;

  assign res_ready = !out_valid_r || out_tready;
  assign res_fire  = res_valid && res_ready;
  assign in_fire   = in_tvalid && in_tready;

  esc_engine #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW(AW),
    .DW(DW)
  ) u_engine (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_symbol(in_tdata),
    .in_is_end(in_tlast),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  esc_stack_ram #(
    .DEPTH(STACK_DEPTH),
    .AW(AW),
    .W(SYM_W)
  ) u_stack (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.code, out_res_r.accepted};
  assign out_tlast  = out_res_r.done;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input taken while an item is still in work");

  a_accept_final: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.accepted) |-> (res.done && res.code == ERR_NONE))
    else $error("accept without end beat or with an error");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.code <= ERR_OVERFLOW))
    else $error("error code out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !res_fire)
    else $error("result register overwritten while held");

endmodule
